// File: rtl/core/tcf_pkg.sv
// Package with shared types, constants and the arctangent table of the tilt filter.
`timescale 1ns / 1ps
`default_nettype none
package tcf_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int TableLen = 24;
   localparam logic signed [23:0] AngLimit = 24'sd5898240;
   localparam logic signed [23:0] QuarterTurn = 24'sd2949120;
   localparam logic [15:0] KinvQ16 = 16'd39797;
   localparam logic [15:0] AlphaReset = 16'd58982;
   localparam logic [15:0] GainReset = 16'd1281;

   localparam logic CsrAlpha = 1'b0;
   localparam logic CsrGain = 1'b1;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic seeded;
   } rsp_type;

   function automatic logic [20:0] atan_entry(input logic [4:0] i);
      case (i)
         5'd0: atan_entry = 21'd1474560;
         5'd1: atan_entry = 21'd870484;
         5'd2: atan_entry = 21'd459940;
         5'd3: atan_entry = 21'd233473;
         5'd4: atan_entry = 21'd117189;
         5'd5: atan_entry = 21'd58652;
         5'd6: atan_entry = 21'd29333;
         5'd7: atan_entry = 21'd14667;
         5'd8: atan_entry = 21'd7334;
         5'd9: atan_entry = 21'd3667;
         5'd10: atan_entry = 21'd1833;
         5'd11: atan_entry = 21'd917;
         5'd12: atan_entry = 21'd458;
         5'd13: atan_entry = 21'd229;
         5'd14: atan_entry = 21'd115;
         5'd15: atan_entry = 21'd57;
         5'd16: atan_entry = 21'd29;
         5'd17: atan_entry = 21'd14;
         5'd18: atan_entry = 21'd7;
         5'd19: atan_entry = 21'd4;
         5'd20: atan_entry = 21'd2;
         5'd21: atan_entry = 21'd1;
         default: atan_entry = 21'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/tcf_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tcf_cordic #(
   parameter int CORDIC_STEPS = tcf_pkg::CordicStepsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [25:0] y_in,
   input  wire logic signed [25:0] x_in,
   output logic                    done,
   output logic signed [23:0]      angle,
   output logic signed [25:0]      mag
);

   localparam int NumIter = (CORDIC_STEPS > tcf_pkg::TableLen) ? tcf_pkg::TableLen
                                                                 : CORDIC_STEPS;
   localparam logic [4:0] LastIter = 5'(NumIter - 1);

   typedef enum logic [1:0] {IDLE, ROTATE, SCALE} state_type;

   state_type state_ff;
   logic [4:0] iter_ff;
   logic signed [27:0] x_ff, y_ff;
   logic signed [25:0] z_ff;
   logic signed [27:0] xs, ys;
   logic signed [25:0] zstep;
   logic signed [44:0] prod;
   logic signed [25:0] zsat;

   // Arithmetic shift is a floor shift for two's complement values.
   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;
   assign zstep = 26'(signed'({1'b0, tcf_pkg::atan_entry(iter_ff)}));
   assign prod = 45'(x_ff) * 45'(signed'({1'b0, tcf_pkg::KinvQ16}));
   assign zsat = (z_ff > 26'(tcf_pkg::AngLimit)) ? 26'(tcf_pkg::AngLimit) :
                 (z_ff < -26'(tcf_pkg::AngLimit)) ? -26'(tcf_pkg::AngLimit) : z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done <= 1'b0;
      end else begin
         done <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start) begin
                  iter_ff <= 5'd0;
                  if (x_in == 26'sd0 && y_in == 26'sd0) begin
                     x_ff <= '0;
                     y_ff <= '0;
                     z_ff <= '0;
                     state_ff <= SCALE;
                  end else begin
                     state_ff <= ROTATE;
                     if (x_in < 0) begin
                        if (y_in >= 0) begin
                           x_ff <= 28'(y_in);
                           y_ff <= -28'(x_in);
                           z_ff <= 26'(tcf_pkg::QuarterTurn);
                        end else begin
                           x_ff <= -28'(y_in);
                           y_ff <= 28'(x_in);
                           z_ff <= -26'(tcf_pkg::QuarterTurn);
                        end
                     end else begin
                        x_ff <= 28'(x_in);
                        y_ff <= 28'(y_in);
                        z_ff <= '0;
                     end
                  end
               end
            end
            ROTATE: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + zstep;
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - zstep;
               end
               iter_ff <= iter_ff + 5'd1;
               if (iter_ff == LastIter) state_ff <= SCALE;
            end
            SCALE: begin
               mag <= 26'(prod >>> 16);
               angle <= 24'(zsat);
               done <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/tilt_complementary_filter_unit.sv
// Top level of the tilt complementary filter: sequencer, blend arithmetic and registers.
// Each item takes two CORDIC runs (roll, then pitch), a gyro step, two products and a sum
// for each axis, and an output state; the seeding item skips the blend and goes to the output.
// The input stalls until the sequencer is idle; a result waits while the last one is stalled.
// Synchronous reset clears the estimates, the primed flag and both registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module tilt_complementary_filter_unit #(
   parameter int CORDIC_STEPS = tcf_pkg::CordicStepsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tcf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tcf_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_data
);

   typedef enum logic [3:0] {
      IDLE, ROLL_GO, ROLL_WAIT, PITCH_GO, PITCH_WAIT,
      R_GYRO, R_MUL_A, R_MUL_B, R_SUM, P_GYRO, P_MUL_A, P_MUL_B, P_SUM, OUTPUT
   } state_type;

   state_type state_ff;
   tcf_pkg::req_type item_ff;
   logic [15:0] alpha_ff, gain_ff;
   logic signed [23:0] roll_ff, pitch_ff, acc_roll_ff, acc_pitch_ff;
   logic primed_ff, seed_ff;
   logic signed [25:0] mag_ff;
   logic signed [47:0] acc_ff, term_ff;
   logic signed [25:0] sum_ff;
   logic signed [17:0] mul_a;
   logic signed [26:0] mul_b;
   logic signed [43:0] mul_p;
   logic signed [47:0] total;
   logic signed [31:0] blended;
   logic signed [23:0] blend_sat;
   logic signed [24:0] out_r, out_p;

   logic cordic_start, cordic_done;
   logic signed [25:0] cy, cx, c_mag;
   logic signed [23:0] c_angle;

   tcf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start), .y_in(cy), .x_in(cx),
      .done(cordic_done), .angle(c_angle), .mag(c_mag)
   );

   assign cordic_start = (state_ff == ROLL_GO) || (state_ff == PITCH_GO);
   assign cy = (state_ff == ROLL_GO) ? 26'(item_ff.accel_y) <<< 8
                                     : -(26'(item_ff.accel_x) <<< 8);
   assign cx = (state_ff == ROLL_GO) ? -(26'(item_ff.accel_z) <<< 8) : mag_ff;

   // One shared multiplier serves the gyro step and both blend products.
   always_comb begin
      case (state_ff)
         R_GYRO: begin
            mul_a = 18'(signed'({1'b0, gain_ff}));
            mul_b = 27'(item_ff.rate_x);
         end
         P_GYRO: begin
            mul_a = 18'(signed'({1'b0, gain_ff}));
            mul_b = 27'(item_ff.rate_y);
         end
         R_MUL_A, P_MUL_A: begin
            mul_a = 18'(signed'({1'b0, alpha_ff}));
            mul_b = 27'(sum_ff);
         end
         R_MUL_B: begin
            mul_a = 18'sd65536 - 18'(signed'({1'b0, alpha_ff}));
            mul_b = 27'(acc_roll_ff);
         end
         P_MUL_B: begin
            mul_a = 18'sd65536 - 18'(signed'({1'b0, alpha_ff}));
            mul_b = 27'(acc_pitch_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = 44'(mul_a) * 44'(mul_b);

   assign total = acc_ff + term_ff + 48'sd32768;
   assign blended = 32'(total >>> 16);
   assign blend_sat = (blended > 32'(tcf_pkg::AngLimit)) ? tcf_pkg::AngLimit :
                      (blended < -32'(tcf_pkg::AngLimit)) ? -tcf_pkg::AngLimit :
                      24'(blended);
   assign out_r = (25'(roll_ff) + 25'sd128) >>> 8;
   assign out_p = (25'(pitch_ff) + 25'sd128) >>> 8;

   assign req_stall = (state_ff != IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid <= 1'b0;
         alpha_ff <= tcf_pkg::AlphaReset;
         gain_ff <= tcf_pkg::GainReset;
         roll_ff <= '0;
         pitch_ff <= '0;
         primed_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               tcf_pkg::CsrAlpha: alpha_ff <= csr_data;
               tcf_pkg::CsrGain: gain_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            IDLE: if (req_valid) begin
               item_ff <= req_data;
               state_ff <= ROLL_GO;
            end
            ROLL_GO: state_ff <= ROLL_WAIT;
            ROLL_WAIT: if (cordic_done) begin
               acc_roll_ff <= c_angle;
               mag_ff <= c_mag;
               state_ff <= PITCH_GO;
            end
            PITCH_GO: state_ff <= PITCH_WAIT;
            PITCH_WAIT: if (cordic_done) begin
               acc_pitch_ff <= c_angle;
               seed_ff <= !primed_ff;
               if (!primed_ff) begin
                  roll_ff <= acc_roll_ff;
                  pitch_ff <= c_angle;
                  primed_ff <= 1'b1;
                  state_ff <= OUTPUT;
               end else begin
                  state_ff <= R_GYRO;
               end
            end
            R_GYRO: begin
               sum_ff <= 26'(roll_ff) + 26'(mul_p >>> 8);
               state_ff <= R_MUL_A;
            end
            R_MUL_A: begin
               acc_ff <= 48'(mul_p);
               state_ff <= R_MUL_B;
            end
            R_MUL_B: begin
               term_ff <= 48'(mul_p);
               state_ff <= R_SUM;
            end
            R_SUM: begin
               roll_ff <= blend_sat;
               state_ff <= P_GYRO;
            end
            P_GYRO: begin
               sum_ff <= 26'(pitch_ff) + 26'(mul_p >>> 8);
               state_ff <= P_MUL_A;
            end
            P_MUL_A: begin
               acc_ff <= 48'(mul_p);
               state_ff <= P_MUL_B;
            end
            P_MUL_B: begin
               term_ff <= 48'(mul_p);
               state_ff <= P_SUM;
            end
            P_SUM: begin
               pitch_ff <= blend_sat;
               state_ff <= OUTPUT;
            end
            OUTPUT: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_valid <= 1'b1;
                  rsp_data.roll_angle <= 16'(out_r);
                  rsp_data.pitch_angle <= 16'(out_p);
                  rsp_data.seeded <= seed_ff;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
         if (rsp_valid && !rsp_stall && state_ff != OUTPUT) rsp_valid <= 1'b0;
      end
   end

   // A stalled result beat must not be overwritten.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat lost under stall");

   // The estimates stay within the saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      roll_ff <= tcf_pkg::AngLimit && roll_ff >= -tcf_pkg::AngLimit &&
      pitch_ff <= tcf_pkg::AngLimit && pitch_ff >= -tcf_pkg::AngLimit)
      else $error("estimate beyond limit");

   // Only the first item after reset may be marked as seeding.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == PITCH_WAIT && cordic_done && primed_ff |=> !seed_ff)
      else $error("seed flag on primed filter");

endmodule
`default_nettype wire
